// ----- rtl/core/pgs_pkg.sv -----
// ----------------------------------------------------------------------------
// pgs_pkg
// Types, widths, status codes and the CORDIC arctangent table shared by the
// panel geometry stream.
// ----------------------------------------------------------------------------
package pgs_pkg;

  localparam int COORD_W   = 16;
  localparam int DIFF_W    = 17;
  localparam int INDEX_W   = 10;
  localparam int ANGLE_W   = 16;
  localparam int SPACING_W = 17;
  localparam int STATUS_W  = 2;
  localparam int CORDIC_W  = 28;
  localparam int ZACC_W    = 33;
  localparam int PRESCALE_SH = 8;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SINGLE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  localparam logic [31:0] INV_GAIN = 32'd2608131496;

  typedef struct packed {
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [DIFF_W-1:0]  sdx;
    logic signed [DIFF_W-1:0]  sdy;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic                      had_prev;
    logic                      last;
  } job_t;

  typedef struct packed {
    logic                      done;
    logic signed [ANGLE_W-1:0] ang;
    logic [SPACING_W-1:0]      mag;
  } cordic_rsp_t;

  // atan(2^-i) in units of pi/2^31
  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933407;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/pgs_if.sv -----
// ----------------------------------------------------------------------------
// pgs_if
// Valid/ready channels for contour points and panel results.
// ----------------------------------------------------------------------------
interface pgs_point_if import pgs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      last_point;

  modport source(output valid, point_x, point_y, last_point, input ready);
  modport sink(input valid, point_x, point_y, last_point, output ready);
endinterface

interface pgs_panel_if import pgs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [INDEX_W-1:0]        panel_index;
  logic signed [COORD_W-1:0] ctrl_x;
  logic signed [COORD_W-1:0] ctrl_y;
  logic signed [ANGLE_W-1:0] angle;
  logic [SPACING_W-1:0]      spacing;
  logic [STATUS_W-1:0]       status;
  logic                      last_panel;

  modport source(output valid, panel_index, ctrl_x, ctrl_y, angle, spacing, status,
                 last_panel, input ready);
  modport sink(input valid, panel_index, ctrl_x, ctrl_y, angle, spacing, status,
               last_panel, output ready);
endinterface

// ----- rtl/core/pgs_front.sv -----
// ----------------------------------------------------------------------------
// pgs_front
// Accepts points, forms control points and differences, queues panel jobs.
// ----------------------------------------------------------------------------
module pgs_front import pgs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  pgs_point_if.sink    point_ch,
  output job_t         job,
  output logic         job_valid,
  input  logic         job_ready
);

  typedef enum logic [1:0] {SEEN_NONE, SEEN_ONE, SEEN_MORE} seen_t;

  seen_t                     seen;
  logic signed [COORD_W-1:0] prev_x, prev_y;
  logic signed [COORD_W-1:0] pend_cx, pend_cy;
  logic signed [DIFF_W-1:0]  sum_x, sum_y;
  logic                      accept;

  assign sum_x = DIFF_W'(point_ch.point_x) + DIFF_W'(prev_x);
  assign sum_y = DIFF_W'(point_ch.point_y) + DIFF_W'(prev_y);

  always_comb begin
    job.cx       = sum_x[DIFF_W-1:1];
    job.cy       = sum_y[DIFF_W-1:1];
    job.dx       = DIFF_W'(point_ch.point_x) - DIFF_W'(prev_x);
    job.dy       = DIFF_W'(point_ch.point_y) - DIFF_W'(prev_y);
    job.sdx      = DIFF_W'(job.cx) - DIFF_W'(pend_cx);
    job.sdy      = DIFF_W'(job.cy) - DIFF_W'(pend_cy);
    job.had_prev = (seen == SEEN_MORE);
    job.last     = point_ch.last_point;
  end

  assign point_ch.ready = (seen == SEEN_NONE) || job_ready;
  assign job_valid      = point_ch.valid && (seen != SEEN_NONE);
  assign accept         = point_ch.valid && point_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= SEEN_NONE;
    end else if (accept) begin
      prev_x <= point_ch.point_x;
      prev_y <= point_ch.point_y;
      if (seen != SEEN_NONE) begin
        pend_cx <= job.cx;
        pend_cy <= job.cy;
      end
      if (point_ch.last_point) begin
        seen <= SEEN_NONE;
      end else if (seen == SEEN_NONE) begin
        seen <= SEEN_ONE;
      end else begin
        seen <= SEEN_MORE;
      end
    end
  end

endmodule

// ----- rtl/core/pgs_queue.sv -----
// ----------------------------------------------------------------------------
// pgs_queue
// Two-entry job FIFO between the front and the back.
// ----------------------------------------------------------------------------
module pgs_queue import pgs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  job_t wr_data,
  input  logic wr_valid,
  output logic wr_ready,
  output job_t rd_data,
  output logic rd_valid,
  input  logic rd_ready
);

  localparam int DEPTH = 2;

  job_t       mem [DEPTH];
  logic       wp, rp;
  logic [1:0] count;
  logic       push, pop;

  assign wr_ready = (count != 2'(DEPTH));
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rp];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wr_data;
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- rtl/core/pgs_cordic.sv -----
// ----------------------------------------------------------------------------
// pgs_cordic
// Iterative CORDIC vectoring: one micro-rotation per cycle, then gain
// correction: multiply, then sum and round. Gives angle and rounded magnitude.
// ----------------------------------------------------------------------------
module pgs_cordic import pgs_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DIFF_W-1:0] dx,
  input  logic signed [DIFF_W-1:0] dy,
  output cordic_rsp_t              rsp
);

  localparam int SW = $clog2(CORDIC_STEPS);

  typedef enum logic [1:0] {C_IDLE, C_ITER, C_MUL, C_MAG} cstate_t;

  cstate_t                    state;
  logic [SW-1:0]              step;
  logic signed [CORDIC_W-1:0] x, y, xs, ys, px, py;
  logic signed [ZACC_W-1:0]   z, z_step, zr;
  logic                       zero;
  logic [CORDIC_W-2:0]        m;
  logic [42:0]                prod_q;
  logic [47:0]                prod_r;
  logic [44:0]                p, pr;
  logic [20:0]                mag_full;

  assign px     = CORDIC_W'(dx) <<< PRESCALE_SH;
  assign py     = CORDIC_W'(dy) <<< PRESCALE_SH;
  assign xs     = x >>> step;
  assign ys     = y >>> step;
  assign z_step = ZACC_W'(atan_entry(5'(step)));
  assign m      = (x > 0) ? x[CORDIC_W-2:0] : '0;
  assign p      = 45'(prod_q) + 45'(prod_r[47:16]);
  assign pr     = p + 45'(1 << 23);
  assign mag_full = pr[44:24];
  assign zr     = z + ZACC_W'(32768);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= C_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == C_MAG);
      case (state)
        C_IDLE: begin
          if (start) begin
            zero <= (dx == '0) && (dy == '0);
            step <= '0;
            if (px < 0) begin
              if (py >= 0) begin
                x <= py;
                y <= -px;
                z <= ZACC_W'(1 << 30);
              end else begin
                x <= -py;
                y <= px;
                z <= -ZACC_W'(1 << 30);
              end
            end else begin
              x <= px;
              y <= py;
              z <= '0;
            end
            state <= C_ITER;
          end
        end
        C_ITER: begin
          if (y >= 0) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + z_step;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - z_step;
          end
          if (step == SW'(CORDIC_STEPS - 1)) begin
            state <= C_MUL;
          end else begin
            step <= step + 1'b1;
          end
        end
        C_MUL: begin
          prod_q <= 43'(m[CORDIC_W-2:16]) * 43'(INV_GAIN);
          prod_r <= 48'(m[15:0]) * 48'(INV_GAIN);
          state  <= C_MAG;
        end
        C_MAG: begin
          if (zero) begin
            rsp.ang <= '0;
            rsp.mag <= '0;
          end else begin
            rsp.ang <= zr[31:16];
            rsp.mag <= (|mag_full[20:17]) ? '1 : mag_full[16:0];
          end
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/pgs_back.sv -----
// ----------------------------------------------------------------------------
// pgs_back
// Runs angle and (given a previous panel) spacing vectorings per job, holds
// the pending panel and issues results through the output register.
// ----------------------------------------------------------------------------
module pgs_back import pgs_pkg::*; #(
  parameter int MAX_PANELS = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  job_t                     job_in,
  input  logic                     job_valid,
  output logic                     job_ready,
  output logic                     cordic_start,
  output logic signed [DIFF_W-1:0] cordic_dx,
  output logic signed [DIFF_W-1:0] cordic_dy,
  input  cordic_rsp_t              rsp,
  pgs_panel_if.source              panel_ch
);

  localparam int IW  = $clog2(MAX_PANELS);
  localparam int CNW = $clog2(MAX_PANELS + 1);

  typedef enum logic [2:0] {B_IDLE, B_ANG, B_SP, B_HELD, B_UPD, B_FINAL} bstate_t;

  bstate_t                   state;
  job_t                      job;
  logic signed [ANGLE_W-1:0] ang_new, pend_ang;
  logic [SPACING_W-1:0]      sp, last_sp;
  logic signed [COORD_W-1:0] pend_cx, pend_cy;
  logic [IW-1:0]             pend_idx, idx_now;
  logic                      pend_ovf, ovf_now;
  logic [CNW-1:0]            cnt;
  logic                      out_free;
  logic                      issue;
  logic                      cordic_start_next;

  assign job_ready = (state == B_IDLE);
  assign out_free  = !panel_ch.valid || panel_ch.ready;
  assign ovf_now   = (cnt >= CNW'(MAX_PANELS));
  assign idx_now   = ovf_now ? IW'(MAX_PANELS - 1) : cnt[IW-1:0];
  assign issue     = ((state == B_HELD) || (state == B_FINAL)) && out_free;
  assign cordic_start_next = ((state == B_IDLE) && job_valid) ||
                             ((state == B_ANG) && rsp.done && job.had_prev);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= B_IDLE;
      cnt            <= '0;
      cordic_start   <= 1'b0;
      panel_ch.valid <= 1'b0;
    end else begin
      cordic_start <= cordic_start_next;
      if (issue) begin
        panel_ch.valid <= 1'b1;
      end else if (panel_ch.valid && panel_ch.ready) begin
        panel_ch.valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            job       <= job_in;
            cordic_dx <= job_in.dx;
            cordic_dy <= job_in.dy;
            state     <= B_ANG;
          end
        end
        B_ANG: begin
          if (rsp.done) begin
            ang_new <= rsp.ang;
            if (job.had_prev) begin
              cordic_dx <= job.sdx;
              cordic_dy <= job.sdy;
              state     <= B_SP;
            end else begin
              state <= B_UPD;
            end
          end
        end
        B_SP: begin
          if (rsp.done) begin
            sp    <= rsp.mag;
            state <= B_HELD;
          end
        end
        B_HELD: begin
          if (out_free) begin
            panel_ch.panel_index <= INDEX_W'(pend_idx);
            panel_ch.ctrl_x      <= pend_cx;
            panel_ch.ctrl_y      <= pend_cy;
            panel_ch.angle       <= pend_ang;
            panel_ch.spacing     <= sp;
            panel_ch.status      <= pend_ovf ? ST_OVERFLOW : ST_OK;
            panel_ch.last_panel  <= 1'b0;
            last_sp  <= sp;
            pend_cx  <= job.cx;
            pend_cy  <= job.cy;
            pend_ang <= ang_new;
            pend_idx <= idx_now;
            pend_ovf <= ovf_now;
            if (!ovf_now) cnt <= cnt + 1'b1;
            state <= job.last ? B_FINAL : B_IDLE;
          end
        end
        B_UPD: begin
          pend_cx  <= job.cx;
          pend_cy  <= job.cy;
          pend_ang <= ang_new;
          pend_idx <= idx_now;
          pend_ovf <= ovf_now;
          if (!ovf_now) cnt <= cnt + 1'b1;
          state <= job.last ? B_FINAL : B_IDLE;
        end
        B_FINAL: begin
          if (out_free) begin
            panel_ch.panel_index <= INDEX_W'(pend_idx);
            panel_ch.ctrl_x      <= pend_cx;
            panel_ch.ctrl_y      <= pend_cy;
            panel_ch.angle       <= pend_ang;
            panel_ch.spacing     <= job.had_prev ? last_sp : '0;
            panel_ch.status      <= !job.had_prev ? ST_SINGLE :
                                    (pend_ovf ? ST_OVERFLOW : ST_OK);
            panel_ch.last_panel  <= 1'b1;
            cnt   <= '0;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/panel_geometry_stream.sv -----
// ----------------------------------------------------------------------------
// panel_geometry_stream
// Contour points in, panel control point, angle and spacing out.
// ----------------------------------------------------------------------------
// Each accepted point after the first of a contour forms one panel job. A
// single shared CORDIC unit runs one vectoring for the panel angle and, from
// the third point of a contour on, one for the spacing: each is a load,
// CORDIC_STEPS iterations and two gain-correction stages, then a handoff,
// and the result register then issues the panel once the receiver is free.
// The first point of a contour is taken without waiting for the back, and
// a two-entry job queue lets the front take points while the back is busy.
// Results lag one panel; the contour's end point releases the held panel
// and the final one.
module panel_geometry_stream import pgs_pkg::*; #(
  parameter int MAX_PANELS   = 1024,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  pgs_point_if.sink   point_ch,
  pgs_panel_if.source panel_ch
);

  job_t                     f_job, q_job;
  logic                     f_valid, f_ready, q_valid, q_ready;
  logic                     c_start;
  logic signed [DIFF_W-1:0] c_dx, c_dy;
  cordic_rsp_t              c_rsp;

  pgs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .point_ch  (point_ch),
    .job       (f_job),
    .job_valid (f_valid),
    .job_ready (f_ready)
  );

  pgs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (f_job),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .rd_data  (q_job),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  pgs_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .dx    (c_dx),
    .dy    (c_dy),
    .rsp   (c_rsp)
  );

  pgs_back #(.MAX_PANELS(MAX_PANELS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_in       (q_job),
    .job_valid    (q_valid),
    .job_ready    (q_ready),
    .cordic_start (c_start),
    .cordic_dx    (c_dx),
    .cordic_dy    (c_dy),
    .rsp          (c_rsp),
    .panel_ch     (panel_ch)
  );

  a_single_final: assert property (@(posedge clk) disable iff (rst)
    (panel_ch.valid && panel_ch.status == ST_SINGLE) |->
      (panel_ch.last_panel && panel_ch.spacing == '0 && panel_ch.panel_index == '0))
    else $error("single-panel transaction malformed");

  a_ovf_index: assert property (@(posedge clk) disable iff (rst)
    (panel_ch.valid && panel_ch.status == ST_OVERFLOW) |->
      (panel_ch.panel_index == INDEX_W'(MAX_PANELS - 1)))
    else $error("overflow transaction without saturated index");

  a_cordic_busy: assert property (@(posedge clk) disable iff (rst)
    c_start |=> !c_start)
    else $error("CORDIC restarted while busy");

endmodule

// ----- tb/pgs_tb_if.sv -----
// ----------------------------------------------------------------------------
// pgs_tb_if
// Testbench record type for one panel result transaction.
// ----------------------------------------------------------------------------
package pgs_tb_types;
  import pgs_pkg::*;

  typedef struct packed {
    logic [INDEX_W-1:0]        panel_index;
    logic signed [COORD_W-1:0] ctrl_x;
    logic signed [COORD_W-1:0] ctrl_y;
    logic signed [ANGLE_W-1:0] angle;
    logic [SPACING_W-1:0]      spacing;
    logic [STATUS_W-1:0]       status;
    logic                      last_panel;
  } panel_rec_t;
endpackage

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Regression for panel_geometry_stream: directed and random contours are streamed
// in with bursty valid and a stalling receiver; an internal panel-geometry
// predictor (CORDIC atan2 and distance) is checked against every result.
// ----------------------------------------------------------------------------
import pgs_pkg::*;
import pgs_tb_types::*;

class panel_scoreboard;
  localparam int NPANEL = 1024;
  longint px, py, pcx, pcy, pang;
  int unsigned seen, pidx;
  bit povf;
  longint lsp;
  panel_rec_t pending_q[$];
  int checked;

  function void clear();
    px = 0; py = 0; pcx = 0; pcy = 0; pang = 0;
    seen = 0; pidx = 0; povf = 0; lsp = 0;
  endfunction

  function longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function void vectoring(longint dx, longint dy, output longint ang, output longint mag);
    longint x, y, z, t, xs, ys, m, q, r, p;
    longint atab[16] = '{536870912, 316933407, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861};
    x = dx * 256; y = dy * 256; z = 0;
    if (dx == 0 && dy == 0) begin
      ang = 0; mag = 0; return;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 64'sd1 << 30;
      end else begin
        x = -y; y = t; z = -(64'sd1 << 30);
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = fshr(x, i); ys = fshr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += atab[i];
      end else begin
        x -= ys; y += xs; z -= atab[i];
      end
    end
    ang = fshr(z + 32768, 16);
    m = x > 0 ? x : 0;
    q = m >> 16; r = m & 16'hFFFF;
    p = q * 64'd2608131496 + ((r * 64'd2608131496) >> 16);
    mag = (p + (64'd1 << 23)) >> 24;
  endfunction

  function void push(int unsigned idx, longint cx, longint cy, longint ang, longint sp,
                     logic [STATUS_W-1:0] st, bit lst);
    panel_rec_t e;
    e.panel_index = idx[INDEX_W-1:0];
    e.ctrl_x = cx[15:0]; e.ctrl_y = cy[15:0]; e.angle = ang[15:0];
    e.spacing = sp > 131071 ? 17'h1FFFF : sp[16:0];
    e.status = st; e.last_panel = lst;
    pending_q.push_back(e);
  endfunction

  function void note_point(logic signed [15:0] x, logic signed [15:0] y, bit lst);
    longint cx, cy, ang, sp, d;
    int unsigned raw;
    bit ovf, hp;
    if (seen == 0) begin
      px = x; py = y; seen = 1;
      if (lst) clear();
      return;
    end
    raw = seen - 1;
    ovf = raw >= NPANEL;
    cx = fshr(px + x, 1); cy = fshr(py + y, 1);
    vectoring(x - px, y - py, ang, d);
    hp = seen >= 2;
    if (hp) begin
      vectoring(cx - pcx, cy - pcy, d, sp);
      push(pidx, pcx, pcy, pang, sp, povf ? ST_OVERFLOW : ST_OK, 0);
      lsp = sp;
    end
    pcx = cx; pcy = cy; pang = ang;
    pidx = ovf ? NPANEL - 1 : raw; povf = ovf;
    px = x; py = y;
    if (seen < NPANEL + 1) seen++;
    if (lst) begin
      if (hp) push(pidx, cx, cy, ang, lsp, povf ? ST_OVERFLOW : ST_OK, 1);
      else push(pidx, cx, cy, ang, 0, ST_SINGLE, 1);
      clear();
    end
  endfunction

  function bit check_panel(panel_rec_t got, output string msg);
    panel_rec_t e;
    if (pending_q.size() == 0) begin
      msg = "unexpected panel result"; return 0;
    end
    e = pending_q.pop_front();
    checked++;
    if (got !== e) begin
      $sformat(msg, {"got idx %0d c(%0d,%0d) a %0d sp %0d st %0d l %0d, ",
                     "want idx %0d c(%0d,%0d) a %0d sp %0d st %0d l %0d"},
        got.panel_index, got.ctrl_x, got.ctrl_y, got.angle, got.spacing, got.status,
        got.last_panel, e.panel_index, e.ctrl_x, e.ctrl_y, e.angle, e.spacing,
        e.status, e.last_panel);
      return 0;
    end
    return 1;
  endfunction
endclass

module tb_top;
  logic clk = 0;
  logic rst = 1;
  always #5 clk = ~clk;

  pgs_point_if point_ch();
  pgs_panel_if panel_ch();

  panel_geometry_stream DUT (.clk(clk), .rst(rst), .point_ch(point_ch), .panel_ch(panel_ch));

  panel_scoreboard sb = new();
  int fails = 0;
  int sent = 0;
  int contours = 0;
  longint cycles = 0;
  bit stall_mode = 0;
  int burst_left = 0;

  task automatic report(string s);
    fails++;
    if (fails <= 30) $display("MISMATCH: %s", s);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > 4000000) begin
      $display("panel_geometry_stream regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    panel_rec_t g;
    string m;
    if (!rst && panel_ch.valid && panel_ch.ready) begin
      g.panel_index = panel_ch.panel_index; g.ctrl_x = panel_ch.ctrl_x;
      g.ctrl_y = panel_ch.ctrl_y; g.angle = panel_ch.angle;
      g.spacing = panel_ch.spacing; g.status = panel_ch.status;
      g.last_panel = panel_ch.last_panel;
      if (!sb.check_panel(g, m)) report(m);
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) stall_mode = ~stall_mode;
    panel_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 9) != 0);
  end

  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, bit lst);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        point_ch.valid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    point_ch.valid <= 1;
    point_ch.point_x <= x; point_ch.point_y <= y; point_ch.last_point <= lst;
    @(posedge clk);
    while (!point_ch.ready) @(posedge clk);
    sb.note_point(x, y, lst);
    sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic contour(int n, int span);
    logic signed [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      if (span == 0) begin
        x = 16'($urandom); y = 16'($urandom);
      end else begin
        x = 16'(int'($urandom_range(0, 2 * span)) - span);
        y = 16'(int'($urandom_range(0, 2 * span)) - span);
      end
      send_point(x, y, i == n - 1);
    end
    contours++;
  endtask

  task automatic drain();
    point_ch.valid <= 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  initial begin
    point_ch.valid = 0; point_ch.point_x = 0; point_ch.point_y = 0;
    point_ch.last_point = 0; panel_ch.ready = 0;
    sb.clear();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // directed
    send_point(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0); send_point(16'sd100, 16'sd0, 1'b1);
    send_point(16'sh8000, 16'sh8000, 1'b0); send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_point(16'sh7FFF, 16'sh7FFF, 1'b0); send_point(16'sh8000, 16'sh7FFF, 1'b0);
    send_point(16'sh7FFF, 16'sh8000, 1'b0); send_point(-16'sd100, 16'sh8000, 1'b1);
    send_point(16'sd500, 16'sd0, 1'b0); send_point(-16'sd500, 16'sd0, 1'b0);
    send_point(-16'sd500, 16'sd700, 1'b0);
    send_point(-16'sd500, -16'sd700, 1'b0); send_point(-16'sd500, -16'sd700, 1'b1);
    drain();
    contour(1030, 0);
    drain();
    for (int k = 0; k < 6; k++) begin
      case ($urandom_range(0, 4))
        0: contour($urandom_range(1, 3), 0);
        1: contour($urandom_range(2, 30), 64);
        default: contour($urandom_range(2, 20), $urandom_range(0, 1) ? 0 : 4000);
      endcase
      if (k == 3) drain();
    end
    drain();
    $display("covered %0d points in %0d contours, %0d panel results checked",
             sent, contours, sb.checked);
    if (fails == 0 && sb.pending_q.size() == 0) begin
      $display("panel_geometry_stream regression: pass");
    end else begin
      $display("panel_geometry_stream regression: fail");
    end
    $finish;
  end
endmodule
